### rtl/csrc_pkg.sv
// shared types and constants for the cursor sprite row compositor
// used by csrc_form_store and cursor_sprite_row_compositor; no dependencies
package csrc_pkg;

  localparam int FORM_ROWS  = 16;
  localparam int MAX_PLANES = 8;
  localparam int ROW_W      = $clog2(FORM_ROWS);
  localparam int WORD_W     = 16;
  localparam int PAIR_W     = 2 * WORD_W;
  localparam int SHIFT_W    = $clog2(WORD_W) + 1;
  localparam int POS_W      = 12;
  localparam int SPOS_W     = POS_W + 1;
  localparam int PLANE_W    = 3;
  localparam int COLOR_W    = 8;
  localparam int HOT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [HOT_W-1:0]   HOT_X_RESET        = 4'd1;
  localparam logic [HOT_W-1:0]   HOT_Y_RESET        = 4'd0;
  localparam logic [COLOR_W-1:0] BG_COLOR_RESET     = 8'd0;
  localparam logic [COLOR_W-1:0] FG_COLOR_RESET     = 8'd1;
  localparam logic [POS_W-1:0]   SCREEN_MAX_X_RESET = 12'd639;
  localparam logic [POS_W-1:0]   SCREEN_MAX_Y_RESET = 12'd399;

  localparam logic [SPOS_W-1:0]  FORM_EDGE = SPOS_W'(WORD_W - 1);

  localparam logic KIND_LOAD      = 1'b0;
  localparam logic KIND_COMPOSITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOT_X        = 3'd0,
    REG_HOT_Y        = 3'd1,
    REG_BG_COLOR     = 3'd2,
    REG_FG_COLOR     = 3'd3,
    REG_SCREEN_MAX_X = 3'd4,
    REG_SCREEN_MAX_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLIP_NONE  = 2'd0,
    CLIP_LEFT  = 2'd1,
    CLIP_RIGHT = 2'd2
  } clip_mode_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] data;
  } form_wr_t;

  typedef struct packed {
    logic               en;
    logic [ROW_W-1:0]   row;
    logic [SHIFT_W-1:0] shift;
  } form_rd_t;

  typedef struct packed {
    logic [PAIR_W-1:0] bg;
    logic [PAIR_W-1:0] fg;
  } form_bits_t;

endpackage

### rtl/csrc_form_store.sv
// cursor form store: mask and data rows, registered read with word-pair shift
// depends on csrc_pkg
module csrc_form_store (
  input  logic                  clk,
  input  csrc_pkg::form_wr_t    wr,
  input  csrc_pkg::form_rd_t    rd,
  output csrc_pkg::form_bits_t  bits
);

  logic [csrc_pkg::WORD_W-1:0] mask_rows [csrc_pkg::FORM_ROWS];
  logic [csrc_pkg::WORD_W-1:0] data_rows [csrc_pkg::FORM_ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mask_rows[wr.row] <= wr.mask;
      data_rows[wr.row] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      bits.bg <= csrc_pkg::PAIR_W'(mask_rows[rd.row]) << rd.shift;
      bits.fg <= csrc_pkg::PAIR_W'(data_rows[rd.row]) << rd.shift;
    end
  end

endmodule

### rtl/cursor_sprite_row_compositor.sv
// cursor sprite row compositor top level: config registers, four-stage pipeline
// depends on csrc_pkg and csrc_form_store
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    kind, form_row, mask_word, data_word, cursor_x,
//                                        cursor_y, plane, visible_row, left_word, right_word
//   result    result_valid / result_stall new_left_word, new_right_word, clip_mode,
//                                        row_visible
//   config    cfg_write_en               cfg_index, cfg_data
//
// one item per cycle unless a stalled result holds the pipeline; a composite result is registered at each stage
// stages: hotspot subtract, clip compare, form read and shift, color merge into output
// load items write the form as they leave the clip stage and give no result
// synchronous reset empties the pipeline and restores the config registers
// a stalled result holds every stage behind it that is full; empty stages keep filling
module cursor_sprite_row_compositor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              kind,
  input  logic [csrc_pkg::ROW_W-1:0]        form_row,
  input  logic [csrc_pkg::WORD_W-1:0]       mask_word,
  input  logic [csrc_pkg::WORD_W-1:0]       data_word,
  input  logic [csrc_pkg::POS_W-1:0]        cursor_x,
  input  logic [csrc_pkg::POS_W-1:0]        cursor_y,
  input  logic [csrc_pkg::PLANE_W-1:0]      plane,
  input  logic [csrc_pkg::ROW_W-1:0]        visible_row,
  input  logic [csrc_pkg::WORD_W-1:0]       left_word,
  input  logic [csrc_pkg::WORD_W-1:0]       right_word,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [csrc_pkg::WORD_W-1:0]       new_left_word,
  output logic [csrc_pkg::WORD_W-1:0]       new_right_word,
  output logic [1:0]                        clip_mode,
  output logic                              row_visible,
  input  logic                              cfg_write_en,
  input  logic [csrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [csrc_pkg::HOT_W-1:0]   hot_x;
  logic [csrc_pkg::HOT_W-1:0]   hot_y;
  logic [csrc_pkg::COLOR_W-1:0] bg_color_bits;
  logic [csrc_pkg::COLOR_W-1:0] fg_color_bits;
  logic [csrc_pkg::POS_W-1:0]   screen_max_x;
  logic [csrc_pkg::POS_W-1:0]   screen_max_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_x         <= csrc_pkg::HOT_X_RESET;
      hot_y         <= csrc_pkg::HOT_Y_RESET;
      bg_color_bits <= csrc_pkg::BG_COLOR_RESET;
      fg_color_bits <= csrc_pkg::FG_COLOR_RESET;
      screen_max_x  <= csrc_pkg::SCREEN_MAX_X_RESET;
      screen_max_y  <= csrc_pkg::SCREEN_MAX_Y_RESET;
    end else if (cfg_write_en) begin
      unique case (csrc_pkg::cfg_reg_t'(cfg_index))
        csrc_pkg::REG_HOT_X:        hot_x         <= cfg_data[csrc_pkg::HOT_W-1:0];
        csrc_pkg::REG_HOT_Y:        hot_y         <= cfg_data[csrc_pkg::HOT_W-1:0];
        csrc_pkg::REG_BG_COLOR:     bg_color_bits <= cfg_data[csrc_pkg::COLOR_W-1:0];
        csrc_pkg::REG_FG_COLOR:     fg_color_bits <= cfg_data[csrc_pkg::COLOR_W-1:0];
        csrc_pkg::REG_SCREEN_MAX_X: screen_max_x  <= cfg_data;
        csrc_pkg::REG_SCREEN_MAX_Y: screen_max_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic s1_valid, s2_valid, s3_valid;
  logic ready1, ready2, ready3, ready4;

  assign ready4     = !result_valid || !result_stall;
  assign ready3     = !s3_valid || ready4;
  assign ready2     = !s2_valid || ready3;
  assign ready1     = !s1_valid || ready2;
  assign item_stall = !ready1;

  // stage 1: hotspot subtract; load items ride in the word slots
  logic                              s1_kind;
  logic [csrc_pkg::SPOS_W-1:0]       s1_x;
  logic [csrc_pkg::SPOS_W-1:0]       s1_y;
  logic [csrc_pkg::PLANE_W-1:0]      s1_plane;
  logic [csrc_pkg::ROW_W-1:0]        s1_row;
  logic [csrc_pkg::WORD_W-1:0]       s1_lw;
  logic [csrc_pkg::WORD_W-1:0]       s1_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_kind  <= kind;
      s1_x     <= {1'b0, cursor_x} - csrc_pkg::SPOS_W'(hot_x);
      s1_y     <= {1'b0, cursor_y} - csrc_pkg::SPOS_W'(hot_y);
      s1_plane <= plane;
      if (kind == csrc_pkg::KIND_LOAD) begin
        s1_row <= form_row;
        s1_lw  <= mask_word;
        s1_rw  <= data_word;
      end else begin
        s1_row <= visible_row;
        s1_lw  <= left_word;
        s1_rw  <= right_word;
      end
    end
  end

  // stage 2: clip compares, form row and shift amount
  logic [csrc_pkg::SPOS_W-1:0]  x_lim, y_lim;
  logic                         x_right, y_top, y_bottom, bottom_ok, plane_ok, vis2;
  logic [csrc_pkg::ROW_W:0]     top_row;
  logic [csrc_pkg::SPOS_W:0]    bottom_sum;
  logic [csrc_pkg::ROW_W-1:0]   fr2;
  logic [1:0]                   mode2;

  always_comb begin
    x_lim      = {1'b0, screen_max_x} - csrc_pkg::FORM_EDGE;
    y_lim      = {1'b0, screen_max_y} - csrc_pkg::FORM_EDGE;
    x_right    = $signed(s1_x) >= $signed(x_lim);
    y_top      = s1_y[csrc_pkg::SPOS_W-1];
    y_bottom   = $signed(s1_y) > $signed(y_lim);
    top_row    = {1'b0, s1_row} - s1_y[csrc_pkg::ROW_W:0];
    bottom_sum = {s1_y[csrc_pkg::SPOS_W-1], s1_y} + (csrc_pkg::SPOS_W + 1)'(s1_row);
    bottom_ok  = $signed(bottom_sum) <= $signed((csrc_pkg::SPOS_W + 1)'(screen_max_y));
    plane_ok   = (csrc_pkg::PLANE_W + 1)'(s1_plane) <
                 (csrc_pkg::PLANE_W + 1)'(csrc_pkg::MAX_PLANES);
    priority if (y_top) begin
      vis2 = !top_row[csrc_pkg::ROW_W];
      fr2  = top_row[csrc_pkg::ROW_W-1:0];
    end else if (y_bottom) begin
      vis2 = bottom_ok;
      fr2  = s1_row;
    end else begin
      vis2 = 1'b1;
      fr2  = s1_row;
    end
    priority if (s1_x[csrc_pkg::SPOS_W-1]) begin
      mode2 = csrc_pkg::CLIP_LEFT;
    end else if (x_right) begin
      mode2 = csrc_pkg::CLIP_RIGHT;
    end else begin
      mode2 = csrc_pkg::CLIP_NONE;
    end
  end

  logic                              s2_kind;
  logic [1:0]                        s2_mode;
  logic                              s2_vis;
  logic [csrc_pkg::ROW_W-1:0]        s2_row;
  logic [csrc_pkg::SHIFT_W-1:0]      s2_shift;
  logic [csrc_pkg::PLANE_W-1:0]      s2_plane;
  logic [csrc_pkg::WORD_W-1:0]       s2_lw;
  logic [csrc_pkg::WORD_W-1:0]       s2_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_kind  <= s1_kind;
      s2_mode  <= mode2;
      s2_vis   <= vis2 && plane_ok;
      s2_row   <= (s1_kind == csrc_pkg::KIND_LOAD) ? s1_row : fr2;
      s2_shift <= csrc_pkg::SHIFT_W'(csrc_pkg::WORD_W) -
                  csrc_pkg::SHIFT_W'(s1_x[csrc_pkg::ROW_W-1:0]);
      s2_plane <= s1_plane;
      s2_lw    <= s1_lw;
      s2_rw    <= s1_rw;
    end
  end

  // stage 3: form write for loads, form read and shift for composites
  csrc_pkg::form_wr_t   form_wr;
  csrc_pkg::form_rd_t   form_rd;
  csrc_pkg::form_bits_t form_bits;

  assign form_wr.en    = s2_valid && ready3 && (s2_kind == csrc_pkg::KIND_LOAD);
  assign form_wr.row   = s2_row;
  assign form_wr.mask  = s2_lw;
  assign form_wr.data  = s2_rw;
  assign form_rd.en    = ready3;
  assign form_rd.row   = s2_row;
  assign form_rd.shift = s2_shift;

  csrc_form_store u_form_store (
    .clk  (clk),
    .wr   (form_wr),
    .rd   (form_rd),
    .bits (form_bits)
  );

  logic [1:0]                        s3_mode;
  logic                              s3_vis;
  logic [csrc_pkg::PLANE_W-1:0]      s3_plane;
  logic [csrc_pkg::WORD_W-1:0]       s3_lw;
  logic [csrc_pkg::WORD_W-1:0]       s3_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid && (s2_kind == csrc_pkg::KIND_COMPOSITE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_mode  <= s2_mode;
      s3_vis   <= s2_vis;
      s3_plane <= s2_plane;
      s3_lw    <= s2_lw;
      s3_rw    <= s2_rw;
    end
  end

  // stage 4: background then foreground merge, pick written words
  logic [csrc_pkg::PAIR_W-1:0] after_bg, after_fg;
  logic [csrc_pkg::WORD_W-1:0] nl4, nr4;

  always_comb begin
    if (bg_color_bits[s3_plane]) begin
      after_bg = {s3_lw, s3_rw} | form_bits.bg;
    end else begin
      after_bg = {s3_lw, s3_rw} & ~form_bits.bg;
    end
    if (fg_color_bits[s3_plane]) begin
      after_fg = after_bg | form_bits.fg;
    end else begin
      after_fg = after_bg & ~form_bits.fg;
    end
    nl4 = s3_lw;
    nr4 = s3_rw;
    if (s3_vis) begin
      if (s3_mode != csrc_pkg::CLIP_LEFT) begin
        nl4 = after_fg[csrc_pkg::PAIR_W-1:csrc_pkg::WORD_W];
      end
      if (s3_mode != csrc_pkg::CLIP_RIGHT) begin
        nr4 = after_fg[csrc_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready4) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      new_left_word  <= nl4;
      new_right_word <= nr4;
      clip_mode      <= s3_mode;
      row_visible    <= s3_vis;
    end
  end

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s2_valid && s3_valid && result_valid))
    else $error("item stall with an empty stage");

  a_clip_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (clip_mode == csrc_pkg::CLIP_NONE ||
                      clip_mode == csrc_pkg::CLIP_LEFT ||
                      clip_mode == csrc_pkg::CLIP_RIGHT))
    else $error("result with unknown clip mode");

  a_held_stage3: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !ready4) |=> s3_valid)
    else $error("stage 3 item lost under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !s1_valid && !s2_valid && !s3_valid))
    else $error("pipeline not empty after reset");

endmodule

### tb/csrc_row_checker.sv
// checker for the cursor sprite row compositor: watches the item, result and config ports,
// predicts each composited row and compares it field by field with what the block returns
// depends on csrc_pkg
module csrc_row_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic                              kind,
  input  logic [csrc_pkg::ROW_W-1:0]        form_row,
  input  logic [csrc_pkg::WORD_W-1:0]       mask_word,
  input  logic [csrc_pkg::WORD_W-1:0]       data_word,
  input  logic [csrc_pkg::POS_W-1:0]        cursor_x,
  input  logic [csrc_pkg::POS_W-1:0]        cursor_y,
  input  logic [csrc_pkg::PLANE_W-1:0]      plane,
  input  logic [csrc_pkg::ROW_W-1:0]        visible_row,
  input  logic [csrc_pkg::WORD_W-1:0]       left_word,
  input  logic [csrc_pkg::WORD_W-1:0]       right_word,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic [csrc_pkg::WORD_W-1:0]       new_left_word,
  input  logic [csrc_pkg::WORD_W-1:0]       new_right_word,
  input  logic [1:0]                        clip_mode,
  input  logic                              row_visible,
  input  logic                              cfg_write_en,
  input  logic [csrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                rows_outstanding,
  output int                                mismatches,
  output int                                rows_checked,
  output int                                rows_shown,
  output int                                left_clips,
  output int                                right_clips
);
  import csrc_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    clip_mode_t        mode;
    logic              vis;
  } row_result_t;

  logic [HOT_W-1:0]   hot_x, hot_y;
  logic [COLOR_W-1:0] bg_bits, fg_bits;
  logic [POS_W-1:0]   max_x, max_y;
  logic [WORD_W-1:0]  form_mask [FORM_ROWS];
  logic [WORD_W-1:0]  form_data [FORM_ROWS];
  row_result_t        pending_rows [$];
  row_result_t        want;

  function automatic row_result_t composite_row(
    input logic [POS_W-1:0]   cx,
    input logic [POS_W-1:0]   cy,
    input logic [PLANE_W-1:0] pl,
    input logic [ROW_W-1:0]   vr,
    input logic [WORD_W-1:0]  lw,
    input logic [WORD_W-1:0]  rw
  );
    int px, py, rows_left, skip;
    logic [ROW_W-1:0]   fr;
    logic [SHIFT_W-1:0] sh;
    logic [PAIR_W-1:0]  under_mask, under_data, pair;
    row_result_t r;
    px = int'(cx) - int'(hot_x);
    py = int'(cy) - int'(hot_y);
    if (px < 0) begin
      px += 16;
      r.mode = CLIP_LEFT;
    end else if (px >= int'(max_x) - 15) begin
      r.mode = CLIP_RIGHT;
    end else begin
      r.mode = CLIP_NONE;
    end
    skip = 0;
    if (py < 0) begin
      rows_left = py + 16;
      skip = -py;
    end else if (py > int'(max_y) - 15) begin
      rows_left = int'(max_y) - py + 1;
    end else begin
      rows_left = 16;
    end
    r.vis = (int'(vr) < rows_left) && (int'(pl) < MAX_PLANES);
    r.left = lw;
    r.right = rw;
    if (r.vis) begin
      fr = ROW_W'(skip + int'(vr));
      sh = SHIFT_W'(16 - (px & 15));
      under_mask = {{WORD_W{1'b0}}, form_mask[fr]} << sh;
      under_data = {{WORD_W{1'b0}}, form_data[fr]} << sh;
      case (r.mode)
        CLIP_LEFT:  pair = {{WORD_W{1'b0}}, rw};
        CLIP_RIGHT: pair = {lw, {WORD_W{1'b0}}};
        default:    pair = {lw, rw};
      endcase
      if (bg_bits[pl]) pair |= under_mask;
      else pair &= ~under_mask;
      if (fg_bits[pl]) pair |= under_data;
      else pair &= ~under_data;
      case (r.mode)
        CLIP_LEFT:  r.right = pair[WORD_W-1:0];
        CLIP_RIGHT: r.left = pair[PAIR_W-1:WORD_W];
        default: begin
          r.left = pair[PAIR_W-1:WORD_W];
          r.right = pair[WORD_W-1:0];
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $time, rows_checked, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hot_x = HOT_X_RESET;
      hot_y = HOT_Y_RESET;
      bg_bits = BG_COLOR_RESET;
      fg_bits = FG_COLOR_RESET;
      max_x = SCREEN_MAX_X_RESET;
      max_y = SCREEN_MAX_Y_RESET;
      mismatches = 0;
      rows_checked = 0;
      rows_shown = 0;
      left_clips = 0;
      right_clips = 0;
      for (int i = 0; i < FORM_ROWS; i++) begin
        form_mask[i] = '0;
        form_data[i] = '0;
      end
      pending_rows.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOT_X:        hot_x = cfg_data[HOT_W-1:0];
          REG_HOT_Y:        hot_y = cfg_data[HOT_W-1:0];
          REG_BG_COLOR:     bg_bits = cfg_data[COLOR_W-1:0];
          REG_FG_COLOR:     fg_bits = cfg_data[COLOR_W-1:0];
          REG_SCREEN_MAX_X: max_x = cfg_data[POS_W-1:0];
          REG_SCREEN_MAX_Y: max_y = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (pending_rows.size() == 0) begin
          report_mismatch($sformatf("row %h/%h arrived with nothing expected",
                                    new_left_word, new_right_word));
        end else begin
          want = pending_rows.pop_front();
          if (new_left_word !== want.left)
            report_mismatch($sformatf("new_left_word %h, expected %h", new_left_word, want.left));
          if (new_right_word !== want.right)
            report_mismatch($sformatf("new_right_word %h, expected %h", new_right_word,
                                      want.right));
          if (clip_mode !== want.mode)
            report_mismatch($sformatf("clip_mode %0d, expected %s", clip_mode, want.mode.name()));
          if (row_visible !== want.vis)
            report_mismatch($sformatf("row_visible %b, expected %b", row_visible, want.vis));
          rows_shown += int'(want.vis);
          left_clips += int'(want.mode == CLIP_LEFT);
          right_clips += int'(want.mode == CLIP_RIGHT);
        end
        rows_checked++;
      end
      if (item_valid && !item_stall) begin
        if (kind == KIND_COMPOSITE) begin
          pending_rows.push_back(composite_row(cursor_x, cursor_y, plane, visible_row,
                                               left_word, right_word));
        end else begin
          form_mask[form_row] = mask_word;
          form_data[form_row] = data_word;
        end
      end
    end
    rows_outstanding <= pending_rows.size();
  end

endmodule

### tb/cursor_sprite_row_compositor_test.sv
// top of the cursor sprite row compositor testbench: clock, reset, config phases,
// directed and random items, result stalls, watchdog and verdict
// depends on csrc_pkg, cursor_sprite_row_compositor and csrc_row_checker
module cursor_sprite_row_compositor_test;
  import csrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  kind = KIND_LOAD;
  logic [ROW_W-1:0]      form_row = '0;
  logic [WORD_W-1:0]     mask_word = '0;
  logic [WORD_W-1:0]     data_word = '0;
  logic [POS_W-1:0]      cursor_x = '0;
  logic [POS_W-1:0]      cursor_y = '0;
  logic [PLANE_W-1:0]    plane = '0;
  logic [ROW_W-1:0]      visible_row = '0;
  logic [WORD_W-1:0]     left_word = '0;
  logic [WORD_W-1:0]     right_word = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [WORD_W-1:0]     new_left_word;
  logic [WORD_W-1:0]     new_right_word;
  logic [1:0]            clip_mode;
  logic                  row_visible;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int rows_outstanding, mismatches, rows_checked, rows_shown, left_clips, right_clips;
  int quiet_cycles = 0;
  int stall_run = 0;
  bit stall_on = 1'b1;
  bit gaps_on = 1'b1;
  int cur_max_x = int'(SCREEN_MAX_X_RESET);
  int cur_max_y = int'(SCREEN_MAX_Y_RESET);
  int loads_sent = 0;
  int composites_sent = 0;
  int settings_used = 1;

  cursor_sprite_row_compositor u_top (.*);
  csrc_row_checker u_checker (.*);

  always #10 clk = ~clk;

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!stall_on) begin
      result_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      result_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= pick_run();
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d rows outstanding",
                 quiet_cycles, rows_outstanding);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(
    input logic               k,
    input logic [ROW_W-1:0]   fr,
    input logic [WORD_W-1:0]  m,
    input logic [WORD_W-1:0]  d,
    input logic [POS_W-1:0]   cx,
    input logic [POS_W-1:0]   cy,
    input logic [PLANE_W-1:0] pl,
    input logic [ROW_W-1:0]   vr,
    input logic [WORD_W-1:0]  lw,
    input logic [WORD_W-1:0]  rw
  );
    int gap;
    gap = (gaps_on && $urandom_range(0, 1)) ? pick_run() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    form_row <= fr;
    mask_word <= m;
    data_word <= d;
    cursor_x <= cx;
    cursor_y <= cy;
    plane <= pl;
    visible_row <= vr;
    left_word <= lw;
    right_word <= rw;
    do @(posedge clk); while (item_stall);
    if (k == KIND_COMPOSITE) composites_sent++;
    else loads_sent++;
  endtask

  task automatic load_row(input logic [ROW_W-1:0] fr, input logic [WORD_W-1:0] m,
                          input logic [WORD_W-1:0] d);
    send_item(KIND_LOAD, fr, m, d, POS_W'($urandom), POS_W'($urandom), PLANE_W'($urandom),
              ROW_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic composite(input int cx, input int cy, input int pl, input int vr,
                           input logic [WORD_W-1:0] lw, input logic [WORD_W-1:0] rw);
    send_item(KIND_COMPOSITE, ROW_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
              POS_W'(cx), POS_W'(cy), PLANE_W'(pl), ROW_W'(vr), lw, rw);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (rows_outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic set_config(input int hx, input int hy, input int bg, input int fg,
                            input int mx, input int my);
    drain_results();
    repeat (8) @(posedge clk);
    write_reg(REG_HOT_X, hx);
    write_reg(REG_HOT_Y, hy);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_SCREEN_MAX_X, mx);
    write_reg(REG_SCREEN_MAX_Y, my);
    cfg_write_en <= 1'b0;
    cur_max_x = mx;
    cur_max_y = my;
    settings_used++;
  endtask

  // biased toward the clip edges of the current screen
  function automatic int pick_coord(input int limit);
    int c;
    case ($urandom_range(0, 3))
      0: c = $urandom_range(0, 20);
      1: c = limit - 15 + $urandom_range(0, 40) - 20;
      2: c = $urandom_range(0, 4095);
      default: c = $urandom_range(0, (limit > 4095) ? 4095 : limit);
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      if ($urandom_range(0, 4) == 0)
        load_row(ROW_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
      else
        composite(pick_coord(cur_max_x), pick_coord(cur_max_y), $urandom_range(0, 7),
                  $urandom_range(0, 15), WORD_W'($urandom), WORD_W'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    load_row(ROW_W'(0), 16'h0000, 16'h0000);
    load_row(ROW_W'(1), 16'hffff, 16'hffff);
    load_row(ROW_W'(2), 16'hffff, 16'h0000);
    load_row(ROW_W'(3), 16'h0000, 16'hffff);
    for (int r = 4; r < FORM_ROWS; r++)
      load_row(ROW_W'(r), WORD_W'($urandom), WORD_W'($urandom));

    composite(0, 0, 0, 0, 16'hffff, 16'h0000);
    composite(4095, 4095, 7, 15, 16'h0000, 16'hffff);
    composite(100, 100, 2, 3, 16'h1234, 16'hfedc);
    composite(17, 50, 0, 1, 16'h0000, 16'h0000);
    composite(626, 10, 0, 2, 16'hffff, 16'hffff);
    composite(300, 390, 0, 9, 16'ha5a5, 16'h5a5a);
    composite(300, 390, 0, 10, 16'ha5a5, 16'h5a5a);

    set_config(15, 15, 255, 0, 4095, 4095);
    composite(0, 0, 3, 0, 16'h0000, 16'h0000);
    composite(0, 0, 3, 1, 16'hffff, 16'hffff);
    composite(4095, 4095, 5, 7, 16'h8001, 16'h7ffe);
    run_random(PHASE_ITEMS);

    set_config(0, 0, 0, 255, 15, 15);
    run_random(PHASE_ITEMS);

    set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(15, 4095), $urandom_range(15, 4095));
    run_random(PHASE_ITEMS);

    gaps_on = 1'b0;
    stall_on = 1'b0;
    set_config(7, 3, 165, 90, 639, 399);
    run_random(PHASE_ITEMS);
    gaps_on = 1'b1;
    stall_on = 1'b1;

    set_config(3, 9, $urandom_range(0, 255), $urandom_range(0, 255), 5, 2);
    run_random(PHASE_ITEMS);

    set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(15, 100), $urandom_range(15, 100));
    run_random(PHASE_ITEMS);

    set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(2000, 4095), $urandom_range(2000, 4095));
    run_random(PHASE_ITEMS);

    set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(15, 4095), $urandom_range(15, 4095));
    run_random(PHASE_ITEMS);

    drain_results();
    repeat (10) @(posedge clk);

    $display("sent %0d form loads and %0d composite rows across %0d register settings",
             loads_sent, composites_sent, settings_used);
    $display("checked %0d rows: %0d visible, %0d left-clipped, %0d right-clipped",
             rows_checked, rows_shown, left_clips, right_clips);
    if (mismatches == 0 && rows_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
